/* rtl/core/setd_pkg.sv */
// Shared types and constants for the spectral energy transient detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package setd_pkg;

  localparam int unsigned EnergyW = 32;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned LockW   = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned FracW   = 8;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgLockout   = 8'd1;

  localparam logic [ThrW-1:0]  ThresholdReset = 12'd512;
  localparam logic [LockW-1:0] LockoutReset   = 8'd10;

  // Completed frame handed from the accumulator to the history cells.
  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic               clear;
    logic [IndexW-1:0]  index;
  } frame_t;

endpackage

/* rtl/core/spectral_energy_transient_detector.sv */
// Top level of the spectral energy transient detector: config registers,
// history cell chain, detection and lockout, output register.
// Depends on setd_pkg, setd_accum and setd_cell.
`timescale 1ns / 1ps

// Usage:
// Bins enter on the input channel (bin_magnitude_i, last_bin_i, restart_i),
// one per cycle. Each bin is added to a saturating frame sum; a bin with
// last_bin_i set closes the frame and yields exactly one result
// (transient_o, frame_index_o) on the output channel. Other bins yield none.
// restart_i on a bin clears the history and the frame count before that bin
// is summed; the lockout counter keeps running across a restart.
// A closed frame is registered in the accumulator and then at the output.
// Throughput: one bin per cycle while in_ready_o is high. The compare and
// threshold multiply after the cell chain (detect stage) are combinational.
// The history is a chain of SPREAD-1 cells that shift once per frame.
// Stall: while the output waits, one more completed frame is held; once that
// slot is full, in_ready_o drops until the receiver takes the result.
// Configuration: index 0 threshold_ratio (Q4.8), index 1 lockout_frames;
// other indexes are ignored. cfg_ready_o is always high.
// Reset: history, sums, counts and lockout clear; registers take 512 and 10.

module spectral_energy_transient_detector #(
  parameter int unsigned SPREAD   = 4,
  parameter int unsigned MAG_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [setd_pkg::MagW-1:0]     bin_magnitude_i,
  input  logic                          last_bin_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          transient_o,
  output logic [setd_pkg::IndexW-1:0]   frame_index_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [setd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [setd_pkg::CfgDataW-1:0] cfg_data_i
);
  import setd_pkg::*;

  localparam int unsigned Cells = SPREAD - 1;
  localparam int unsigned ProdW = EnergyW + ThrW;

  logic [ThrW-1:0]  thr_q, thr_d;
  logic [LockW-1:0] lock_frames_q, lock_frames_d;
  logic [LockW-1:0] lock_q, lock_d;
  logic             out_valid_q, out_valid_d;
  logic             transient_q, transient_d;
  logic [IndexW-1:0] index_q, index_d;

  logic   accept;
  logic   fr_valid;
  logic   fr_take;
  frame_t frame;

  logic [EnergyW-1:0] chain [Cells+1];
  logic [Cells-1:0]   rising;

  logic [ProdW-1:0] lhs;
  logic [ProdW-1:0] rhs;
  logic             hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d         = thr_q;
    lock_frames_d = lock_frames_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgThreshold: thr_d = cfg_data_i[ThrW-1:0];
        CfgLockout:   lock_frames_d = cfg_data_i[LockW-1:0];
        default: ;
      endcase
    end
  end

  assign fr_take    = fr_valid && (!out_valid_q || out_ready_i);
  assign in_ready_o = !fr_valid || fr_take;
  assign accept     = in_valid_i && in_ready_o;

  setd_accum #(
    .MAG_BITS(MAG_BITS)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .bin_magnitude_i (bin_magnitude_i),
    .last_bin_i      (last_bin_i),
    .restart_i       (restart_i),
    .take_i          (fr_take),
    .frame_valid_o   (fr_valid),
    .frame_o         (frame)
  );

  assign chain[0] = frame.energy;

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    setd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (fr_take),
      .clear_i  (frame.clear),
      .energy_i (chain[k]),
      .energy_o (chain[k+1]),
      .rising_o (rising[k])
    );
  end

  // Newest is the incoming frame, oldest is what the last cell hands on.
  assign lhs = {(ThrW - FracW)'(0), frame.energy, FracW'(0)};
  assign rhs = chain[Cells] * {(ProdW - ThrW)'(0), thr_q};
  assign hit = (lock_q == '0) && (&rising) && (lhs > rhs);

  always_comb begin
    lock_d      = lock_q;
    out_valid_d = out_valid_q;
    transient_d = transient_q;
    index_d     = index_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fr_take) begin
      out_valid_d = 1'b1;
      transient_d = hit;
      index_d     = frame.index;
      if (hit) begin
        lock_d = lock_frames_q;
      end else if (lock_q != '0) begin
        lock_d = lock_q - LockW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= ThresholdReset;
      lock_frames_q <= LockoutReset;
      lock_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      thr_q         <= thr_d;
      lock_frames_q <= lock_frames_d;
      lock_q        <= lock_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    transient_q <= transient_d;
    index_q     <= index_d;
  end

  assign out_valid_o   = out_valid_q;
  assign transient_o   = transient_q;
  assign frame_index_o = index_q;

endmodule

/* rtl/core/setd_accum.sv */
// Bin accumulator: saturating frame energy sum, frame counter and frame request register.
// Depends on setd_pkg.
`timescale 1ns / 1ps

module setd_accum #(
  parameter int unsigned MAG_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [setd_pkg::MagW-1:0] bin_magnitude_i,
  input  logic                    last_bin_i,
  input  logic                    restart_i,
  input  logic                    take_i,
  output logic                    frame_valid_o,
  output setd_pkg::frame_t        frame_o
);
  import setd_pkg::*;

  localparam int unsigned UsedW = (MAG_BITS < MagW) ? MAG_BITS : MagW;
  localparam logic [MagW-1:0] MagMask = MagW'((33'd1 << UsedW) - 33'd1);

  logic [EnergyW-1:0] acc_q, acc_d;
  logic [IndexW-1:0]  fc_q, fc_d;
  logic               clr_pend_q, clr_pend_d;
  logic               fr_valid_q, fr_valid_d;
  frame_t             fr_q, fr_d;

  logic [EnergyW-1:0] base_acc;
  logic [EnergyW:0]   sum_wide;
  logic [EnergyW-1:0] sum_sat;
  logic [IndexW-1:0]  base_fc;
  logic               clr;

  always_comb begin
    base_acc = restart_i ? '0 : acc_q;
    sum_wide = {1'b0, base_acc} + {(EnergyW + 1 - MagW)'(0), bin_magnitude_i & MagMask};
    sum_sat  = sum_wide[EnergyW] ? '1 : sum_wide[EnergyW-1:0];
    base_fc  = restart_i ? '0 : fc_q;
    clr      = restart_i | clr_pend_q;

    acc_d      = acc_q;
    fc_d       = fc_q;
    clr_pend_d = clr_pend_q;
    fr_d       = fr_q;
    fr_valid_d = fr_valid_q;
    if (take_i) begin
      fr_valid_d = 1'b0;
    end
    if (accept_i) begin
      if (last_bin_i) begin
        acc_d        = '0;
        fc_d         = base_fc + IndexW'(1);
        clr_pend_d   = 1'b0;
        fr_d.energy  = sum_sat;
        fr_d.clear   = clr;
        fr_d.index   = base_fc;
        fr_valid_d   = 1'b1;
      end else begin
        acc_d      = sum_sat;
        fc_d       = base_fc;
        clr_pend_d = clr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      fc_q       <= '0;
      clr_pend_q <= 1'b0;
      fr_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      fc_q       <= fc_d;
      clr_pend_q <= clr_pend_d;
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
  end

  assign frame_valid_o = fr_valid_q;
  assign frame_o       = fr_q;

endmodule

/* rtl/core/setd_cell.sv */
// One history cell: holds one frame energy, passes it downstream on a shift.
// Depends on setd_pkg.
`timescale 1ns / 1ps

module setd_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic                        clear_i,
  input  logic [setd_pkg::EnergyW-1:0] energy_i,
  output logic [setd_pkg::EnergyW-1:0] energy_o,
  output logic                        rising_o
);
  import setd_pkg::*;

  logic [EnergyW-1:0] energy_q, energy_d;

  // A pending clear makes the cell read as empty before the shift.
  assign energy_o = clear_i ? '0 : energy_q;
  assign rising_o = energy_i > energy_o;
  assign energy_d = shift_i ? energy_i : energy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else begin
      energy_q <= energy_d;
    end
  end

endmodule

/* rtl/core/setd_checker.sv */
// Port-level checks for the spectral energy transient detector, bound to the top level.
// Depends on setd_pkg and spectral_energy_transient_detector.
`timescale 1ns / 1ps

module setd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_bin_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          transient_o,
  input logic [setd_pkg::IndexW-1:0]   frame_index_o,
  input logic                          cfg_ready_o
);
  import setd_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(transient_o)
      && $stable(frame_index_o))
    else $error("stalled result changed or dropped");

  // Drop input ready only behind a stalled result.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // The held frame slot fills only from a request that closed a frame.
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && last_bin_i))
    else $error("input ready fell without a completed frame");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind spectral_energy_transient_detector setd_checker u_setd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .last_bin_i    (last_bin_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .transient_o   (transient_o),
  .frame_index_o (frame_index_o),
  .cfg_ready_o   (cfg_ready_o)
);
